@@ src/sge_pkg.sv @@
// Shared types and constants for the state-vector gate engine.
// Used by sge_ctrl, sge_dp and statevector_gate_engine_top; no dependencies.
package sge_pkg;

    localparam int QB_W  = 4;   // qubit index field width
    localparam int CNT_W = 4;   // qubit count register width
    localparam int OP_W  = 4;   // operation code width
    localparam int Z_W   = 32;  // expectation output width

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE   = 4'd0;
    localparam logic [OP_W-1:0] OP_READ    = 4'd1;
    localparam logic [OP_W-1:0] OP_BASIS   = 4'd2;
    localparam logic [OP_W-1:0] OP_GATE1Q  = 4'd3;
    localparam logic [OP_W-1:0] OP_CNOT    = 4'd4;
    localparam logic [OP_W-1:0] OP_CZ      = 4'd5;
    localparam logic [OP_W-1:0] OP_SWAP    = 4'd6;
    localparam logic [OP_W-1:0] OP_TOFFOLI = 4'd7;
    localparam logic [OP_W-1:0] OP_CY      = 4'd8;
    localparam logic [OP_W-1:0] OP_CPHASE  = 4'd9;
    localparam logic [OP_W-1:0] OP_CSWAP   = 4'd10;
    localparam logic [OP_W-1:0] OP_EXPZ    = 4'd11;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_CLEAR,
        S_SETONE,
        S_RDWAIT,
        S_SCAN,
        S_RDJ,
        S_LDJ,
        S_MUL,
        S_SUM,
        S_RES,
        S_FINISH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic in_load;
        logic cnt_clr;
        logic cnt_inc;
        logic rd_i;
        logic rd_j;
        logic rd_idx;
        logic ld_x0;
        logic ld_x1;
        logic mul_en;
        logic sum_en;
        logic k_hi;
        logic wr_res;
        logic wr_zero;
        logic wr_one;
        logic wr_amp;
        logic acc_clr;
        logic acc_en;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            bad;
        logic            sel;
        logic            scan_end;
        logic            clr_end;
    } stat_t;

    // Operations that rewrite a pair of amplitudes
    function automatic logic is_pair(input logic [OP_W-1:0] op);
        logic r;
        r = (op == OP_GATE1Q) || (op == OP_CNOT) || (op == OP_SWAP) ||
            (op == OP_TOFFOLI) || (op == OP_CY) || (op == OP_CSWAP);
        return r;
    endfunction

    // Operations that sweep the state vector
    function automatic logic is_sweep(input logic [OP_W-1:0] op);
        logic r;
        r = is_pair(op) || (op == OP_CZ) || (op == OP_CPHASE) || (op == OP_EXPZ);
        return r;
    endfunction

endpackage

@@ src/sge_ctrl.sv @@
// Controller state machine of the state-vector gate engine.
// Depends on sge_pkg; drives sge_dp through cmd_t and watches stat_t.
module sge_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  sge_pkg::stat_t stat,
    output sge_pkg::cmd_t  cmd
);
    import sge_pkg::*;

    state_t state_reg, state_next;
    logic   k_reg, k_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // State, half select and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (stat.bad)
                    state_next = S_FINISH;
                else if (stat.op == OP_READ)
                    state_next = S_RDWAIT;
                else if (stat.op == OP_BASIS)
                    state_next = S_CLEAR;
                else if (is_sweep(stat.op))
                    state_next = S_SCAN;
                else
                    state_next = S_FINISH;
            end
            S_CLEAR:
            begin
                if (stat.clr_end)
                    state_next = S_SETONE;
            end
            S_SETONE: state_next = S_FINISH;
            S_RDWAIT: state_next = S_FINISH;
            S_SCAN:
            begin
                if (stat.scan_end)
                    state_next = S_FINISH;
                else if (stat.sel)
                    state_next = S_RDJ;
            end
            S_RDJ: state_next = S_LDJ;
            S_LDJ:
            begin
                k_next     = 1'b0;
                state_next = S_MUL;
            end
            S_MUL: state_next = S_SUM;
            S_SUM: state_next = S_RES;
            S_RES:
            begin
                if (!k_reg && is_pair(stat.op))
                begin
                    k_next     = 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    k_next     = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold the result until the receiver takes it
    always_comb
    begin
        if (state_reg == S_FINISH && out_free)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.in_load = in_valid;
            end
            S_DECODE:
            begin
                if (!stat.bad)
                begin
                    if (stat.op == OP_WRITE)
                        cmd.wr_amp = 1'b1;
                    else if (stat.op == OP_READ)
                        cmd.rd_idx = 1'b1;
                    else if (stat.op == OP_BASIS)
                        cmd.cnt_clr = 1'b1;
                    else if (is_sweep(stat.op))
                    begin
                        cmd.cnt_clr = 1'b1;
                        cmd.acc_clr = 1'b1;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.wr_zero = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            S_SETONE: cmd.wr_one = 1'b1;
            S_SCAN:
            begin
                if (!stat.scan_end)
                begin
                    if (stat.sel)
                        cmd.rd_i = 1'b1;
                    else
                        cmd.cnt_inc = 1'b1;
                end
            end
            S_RDJ:
            begin
                cmd.rd_j  = 1'b1;
                cmd.ld_x0 = 1'b1;
            end
            S_LDJ: cmd.ld_x1 = 1'b1;
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.k_hi   = k_reg;
            end
            S_SUM: cmd.sum_en = 1'b1;
            S_RES:
            begin
                cmd.k_hi = k_reg;
                if (stat.op == OP_EXPZ)
                    cmd.acc_en = 1'b1;
                else
                    cmd.wr_res = 1'b1;
                if (!(!k_reg && is_pair(stat.op)))
                    cmd.cnt_inc = 1'b1;
            end
            S_FINISH: cmd.out_load = out_free;
            default: cmd = '0;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

@@ src/sge_dp.sv @@
// Datapath of the state-vector gate engine: amplitude memory, index counter,
// multiplier bank, rounding, expectation accumulator. Depends on sge_pkg.
module sge_dp #(
    parameter int MAX_QUBITS = 10,
    parameter int PART_BITS  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sge_pkg::CNT_W-1:0]        cfg_data,
    input  logic [sge_pkg::OP_W-1:0]         operation,
    input  logic [sge_pkg::QB_W-1:0]         qubit_a,
    input  logic [sge_pkg::QB_W-1:0]         qubit_b,
    input  logic [sge_pkg::QB_W-1:0]         qubit_c,
    input  logic [MAX_QUBITS-1:0]            amp_index,
    input  logic [2*PART_BITS-1:0]           amp_value,
    input  logic [2*PART_BITS-1:0]           gate_m00,
    input  logic [2*PART_BITS-1:0]           gate_m01,
    input  logic [2*PART_BITS-1:0]           gate_m10,
    input  logic [2*PART_BITS-1:0]           gate_m11,
    input  sge_pkg::cmd_t                    cmd,
    output sge_pkg::stat_t                   stat,
    output logic [2*PART_BITS-1:0]           amp_out,
    output logic signed [sge_pkg::Z_W-1:0]   z_expectation,
    output logic                             status
);
    import sge_pkg::*;

    localparam int AMP_W  = 2 * PART_BITS;
    localparam int DEPTH  = 1 << MAX_QUBITS;
    localparam int IW     = MAX_QUBITS + 1;
    localparam int FRAC   = PART_BITS - 2;
    localparam int PROD_W = 2 * PART_BITS;
    localparam int SUM_W  = 2 * PART_BITS + 3;
    localparam int ACC_W  = (SUM_W > 64) ? SUM_W : 64;

    localparam logic signed [SUM_W-1:0] HALF_S = SUM_W'(64'd1 << (FRAC - 1));
    localparam logic signed [SUM_W-1:0] PMAX_S = SUM_W'((64'd1 << (PART_BITS - 1)) - 64'd1);
    localparam logic signed [SUM_W-1:0] PMIN_S = -PMAX_S - SUM_W'(1);
    localparam logic signed [PART_BITS-1:0] PMAX_P = {1'b0, {(PART_BITS-1){1'b1}}};
    localparam logic signed [PART_BITS-1:0] PMIN_P = {1'b1, {(PART_BITS-1){1'b0}}};
    localparam logic signed [PART_BITS-1:0] ONE_P  = PART_BITS'(64'd1 << FRAC);
    localparam logic signed [ACC_W-1:0] ZCAP   = ACC_W'(64'd1 << 61);
    localparam logic signed [ACC_W-1:0] ZMAX_A = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] ZMIN_A = -ZMAX_A - ACC_W'(1);

    // Round to nearest (ties up) and saturate one part
    function automatic logic signed [PART_BITS-1:0] rnd_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] t;
        logic signed [PART_BITS-1:0] r;
        t = (s + HALF_S) >>> FRAC;
        if (t > PMAX_S)
            r = PMAX_P;
        else if (t < PMIN_S)
            r = PMIN_P;
        else
            r = PART_BITS'(t);
        return r;
    endfunction

    // Saturating negate
    function automatic logic signed [PART_BITS-1:0] neg_sat(input logic signed [PART_BITS-1:0] v);
        logic signed [PART_BITS-1:0] r;
        if (v == PMIN_P)
            r = PMAX_P;
        else
            r = -v;
        return r;
    endfunction

    logic [CNT_W-1:0]       qcount_reg;
    logic [OP_W-1:0]        op_reg;
    logic [QB_W-1:0]        qa_reg, qb_reg, qc_reg;
    logic [MAX_QUBITS-1:0]  idx_reg;
    logic [AMP_W-1:0]       val_reg, m00_reg, m01_reg, m10_reg, m11_reg;
    logic [IW-1:0]          cnt_reg;
    logic [AMP_W-1:0]       x0_reg, x1_reg, rd_data_reg;
    logic signed [PROD_W-1:0] prod_reg [8];
    logic signed [SUM_W-1:0]  sre_reg, sim_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [AMP_W-1:0]       amp_out_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic                   status_reg;
    logic [AMP_W-1:0]       mem [DEPTH];

    logic [CNT_W-1:0]       cnt_eff;
    logic [IW-1:0]          n_val, n_mask;
    logic [MAX_QUBITS-1:0]  idx_eff, ii, jj, ma, mb, mc;
    logic                   bad, sel;
    logic [AMP_W-1:0]       c0, c1, res_word, mac_word;
    logic signed [PART_BITS-1:0] x0_re, x0_im, x1_re, x1_im;
    logic signed [PART_BITS-1:0] c0_re, c0_im, c1_re, c1_im;
    logic signed [PART_BITS-1:0] opa [8];
    logic signed [PART_BITS-1:0] opb [8];
    logic signed [ACC_W-1:0] term_ext, term_cap, acc_sum;
    logic signed [Z_W-1:0]   z_clamp;
    logic                    wr_en, rd_en;
    logic [MAX_QUBITS-1:0]   wr_addr, rd_addr;
    logic [AMP_W-1:0]        wr_data;

    // Configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qcount_reg <= CNT_W'(1);
        else if (cfg_valid)
            qcount_reg <= cfg_data;
    end

    // Capture the input transaction
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            op_reg  <= operation;
            qa_reg  <= qubit_a;
            qb_reg  <= qubit_b;
            qc_reg  <= qubit_c;
            idx_reg <= amp_index;
            val_reg <= amp_value;
            m00_reg <= gate_m00;
            m01_reg <= gate_m01;
            m10_reg <= gate_m10;
            m11_reg <= gate_m11;
        end
    end

    // Effective qubit count, state length and index wrap
    always_comb
    begin
        if (qcount_reg == '0)
            cnt_eff = CNT_W'(1);
        else if (32'(qcount_reg) > MAX_QUBITS)
            cnt_eff = CNT_W'(MAX_QUBITS);
        else
            cnt_eff = qcount_reg;
    end
    assign n_val   = IW'(1) << cnt_eff;
    assign n_mask  = n_val - IW'(1);
    assign idx_eff = idx_reg & n_mask[MAX_QUBITS-1:0];

    // Qubit range check
    always_comb
    begin
        case (op_reg)
            OP_GATE1Q, OP_EXPZ:
                bad = (qa_reg >= cnt_eff);
            OP_CNOT, OP_CZ, OP_SWAP, OP_CY, OP_CPHASE:
                bad = (qa_reg >= cnt_eff) || (qb_reg >= cnt_eff);
            OP_TOFFOLI, OP_CSWAP:
                bad = (qa_reg >= cnt_eff) || (qb_reg >= cnt_eff) || (qc_reg >= cnt_eff);
            default:
                bad = 1'b0;
        endcase
    end

    assign ma = MAX_QUBITS'(1) << qa_reg;
    assign mb = MAX_QUBITS'(1) << qb_reg;
    assign mc = MAX_QUBITS'(1) << qc_reg;
    assign ii = cnt_reg[MAX_QUBITS-1:0];

    // Select the indices a sweep touches and their partners
    always_comb
    begin
        sel = 1'b0;
        jj  = ii;
        case (op_reg)
            OP_GATE1Q:
            begin
                sel = (ii & ma) == '0;
                jj  = ii | ma;
            end
            OP_CNOT, OP_CY:
            begin
                sel = ((ii & mb) != '0) && ((ii & ma) == '0);
                jj  = ii | ma;
            end
            OP_TOFFOLI:
            begin
                sel = ((ii & mb) != '0) && ((ii & mc) != '0) && ((ii & ma) == '0);
                jj  = ii | ma;
            end
            OP_CZ, OP_CPHASE:
                sel = ((ii & mb) != '0) && ((ii & ma) != '0);
            OP_SWAP:
            begin
                sel = ((ii & ma) != '0) && ((ii & mb) == '0);
                jj  = (ii & ~ma) | mb;
            end
            OP_CSWAP:
            begin
                sel = ((ii & mb) != '0) && ((ii & ma) != '0) && ((ii & mc) == '0);
                jj  = (ii & ~ma) | mc;
            end
            OP_EXPZ:
                sel = 1'b1;
            default:
                sel = 1'b0;
        endcase
    end

    // Index counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.cnt_clr)
            cnt_reg <= '0;
        else if (cmd.cnt_inc)
            cnt_reg <= cnt_reg + IW'(1);
    end

    assign stat.op       = op_reg;
    assign stat.bad      = bad;
    assign stat.sel      = sel;
    assign stat.scan_end = (cnt_reg == n_val);
    assign stat.clr_end  = (cnt_reg == IW'(DEPTH - 1));

    // Memory port selection
    always_comb
    begin
        wr_en   = cmd.wr_zero || cmd.wr_one || cmd.wr_amp || cmd.wr_res;
        wr_addr = ii;
        wr_data = '0;
        if (cmd.wr_one)
        begin
            wr_addr = idx_eff;
            wr_data = {ONE_P, {PART_BITS{1'b0}}};
        end
        else if (cmd.wr_amp)
        begin
            wr_addr = idx_eff;
            wr_data = val_reg;
        end
        else if (cmd.wr_res)
        begin
            wr_addr = cmd.k_hi ? jj : ii;
            wr_data = res_word;
        end
        rd_en   = cmd.rd_i || cmd.rd_j || cmd.rd_idx;
        if (cmd.rd_idx)
            rd_addr = idx_eff;
        else if (cmd.rd_j)
            rd_addr = jj;
        else
            rd_addr = ii;
    end

    // Amplitude memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Operand registers
    always_ff @(posedge clk)
    begin
        if (cmd.ld_x0)
            x0_reg <= rd_data_reg;
        if (cmd.ld_x1)
            x1_reg <= rd_data_reg;
    end

    assign x0_re = x0_reg[AMP_W-1:PART_BITS];
    assign x0_im = x0_reg[PART_BITS-1:0];
    assign x1_re = x1_reg[AMP_W-1:PART_BITS];
    assign x1_im = x1_reg[PART_BITS-1:0];

    // Matrix row for this half
    always_comb
    begin
        if (op_reg == OP_CPHASE)
        begin
            c0 = m11_reg;
            c1 = '0;
        end
        else if (cmd.k_hi)
        begin
            c0 = m10_reg;
            c1 = m11_reg;
        end
        else
        begin
            c0 = m00_reg;
            c1 = m01_reg;
        end
    end

    assign c0_re = c0[AMP_W-1:PART_BITS];
    assign c0_im = c0[PART_BITS-1:0];
    assign c1_re = c1[AMP_W-1:PART_BITS];
    assign c1_im = c1[PART_BITS-1:0];

    // Multiplier operands: complex multiply-add, or squared magnitude
    always_comb
    begin
        if (op_reg == OP_EXPZ)
        begin
            for (int n = 0; n < 8; n++)
            begin
                opa[n] = '0;
                opb[n] = '0;
            end
            opa[4] = x0_re;
            opb[4] = x0_re;
            opa[5] = x0_im;
            opb[5] = x0_im;
        end
        else
        begin
            opa[0] = c0_re; opb[0] = x0_re;
            opa[1] = c0_im; opb[1] = x0_im;
            opa[2] = c1_re; opb[2] = x1_re;
            opa[3] = c1_im; opb[3] = x1_im;
            opa[4] = c0_re; opb[4] = x0_im;
            opa[5] = c0_im; opb[5] = x0_re;
            opa[6] = c1_re; opb[6] = x1_im;
            opa[7] = c1_im; opb[7] = x1_re;
        end
    end

    // Multiplier bank
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            for (int n = 0; n < 8; n++)
                prod_reg[n] <= opa[n] * opb[n];
        end
    end

    // Exact sums of the products
    always_ff @(posedge clk)
    begin
        if (cmd.sum_en)
        begin
            sre_reg <= SUM_W'(prod_reg[0]) - SUM_W'(prod_reg[1])
                     + SUM_W'(prod_reg[2]) - SUM_W'(prod_reg[3]);
            sim_reg <= SUM_W'(prod_reg[4]) + SUM_W'(prod_reg[5])
                     + SUM_W'(prod_reg[6]) + SUM_W'(prod_reg[7]);
        end
    end

    assign mac_word = {rnd_sat(sre_reg), rnd_sat(sim_reg)};

    // Result word for the amplitude being written
    always_comb
    begin
        case (op_reg)
            OP_GATE1Q, OP_CPHASE:
                res_word = mac_word;
            OP_CNOT, OP_SWAP, OP_TOFFOLI, OP_CSWAP:
                res_word = cmd.k_hi ? x0_reg : x1_reg;
            OP_CY:
                res_word = cmd.k_hi ? {neg_sat(x0_im), x0_re} : {x1_im, neg_sat(x1_re)};
            OP_CZ:
                res_word = {neg_sat(x0_re), neg_sat(x0_im)};
            default:
                res_word = x0_reg;
        endcase
    end

    // Expectation accumulator, clamped each step
    assign term_ext = ACC_W'(sim_reg);
    assign term_cap = (term_ext > ZCAP) ? ZCAP : term_ext;
    assign acc_sum  = ((ii & ma) != '0) ? acc_reg - term_cap : acc_reg + term_cap;
    always_comb
    begin
        if (acc_sum > ZCAP)
            acc_next = ZCAP;
        else if (acc_sum < -ZCAP)
            acc_next = -ZCAP;
        else
            acc_next = acc_sum;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (cmd.acc_en)
            acc_reg <= acc_next;
    end

    always_comb
    begin
        if (acc_reg > ZMAX_A)
            z_clamp = Z_W'(ZMAX_A);
        else if (acc_reg < ZMIN_A)
            z_clamp = Z_W'(ZMIN_A);
        else
            z_clamp = Z_W'(acc_reg);
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            amp_out_reg <= (op_reg == OP_READ && !bad) ? rd_data_reg : '0;
            z_reg       <= (op_reg == OP_EXPZ && !bad) ? z_clamp : '0;
            status_reg  <= bad;
        end
    end

    assign amp_out       = amp_out_reg;
    assign z_expectation = z_reg;
    assign status        = status_reg;

endmodule

@@ src/statevector_gate_engine_top.sv @@
// State-vector gate engine: a transaction on the input channel names one
// operation on a store of 2^qubit_count packed complex amplitudes.
// Channels: in_valid/in_ready carry the operation and its operands;
// out_valid/out_ready return amp_out, z_expectation and status, one result
// per input transaction, in order; cfg_valid/cfg_ready write qubit_count.
// Write qubit_count only while no transaction is in flight.
// A gate or expectation sweeps every index once; each amplitude touched alone
// (cz, cphase, expz) passes once through the read, multiply, sum and result
// states, and each pair rewritten (1q gate, cnot, swap, toffoli, cy, cswap)
// passes twice through multiply, sum and result. The single memory read port
// and the shared multiplier bank set the length of a sweep. A basis-state set
// clears all 2^MAX_QUBITS entries, one a cycle, then writes the 1.
// One transaction is worked at a time; a new one is taken while the last
// result still waits in the output register. A stalled receiver holds the
// result and stops the engine at the end of its next transaction.
// Reset: qubit_count returns to 1, control returns to idle; amplitudes stay
// undefined until written or set by a basis-state operation.
module statevector_gate_engine_top #(
    parameter int MAX_QUBITS = 10,
    parameter int PART_BITS  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sge_pkg::CNT_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sge_pkg::OP_W-1:0]         operation,
    input  logic [sge_pkg::QB_W-1:0]         qubit_a,
    input  logic [sge_pkg::QB_W-1:0]         qubit_b,
    input  logic [sge_pkg::QB_W-1:0]         qubit_c,
    input  logic [MAX_QUBITS-1:0]            amp_index,
    input  logic [2*PART_BITS-1:0]           amp_value,
    input  logic [2*PART_BITS-1:0]           gate_m00,
    input  logic [2*PART_BITS-1:0]           gate_m01,
    input  logic [2*PART_BITS-1:0]           gate_m10,
    input  logic [2*PART_BITS-1:0]           gate_m11,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [2*PART_BITS-1:0]           amp_out,
    output logic signed [sge_pkg::Z_W-1:0]   z_expectation,
    output logic                             status
);
    import sge_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Controller
    sge_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath
    sge_dp #(
        .MAX_QUBITS (MAX_QUBITS),
        .PART_BITS  (PART_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .operation     (operation),
        .qubit_a       (qubit_a),
        .qubit_b       (qubit_b),
        .qubit_c       (qubit_c),
        .amp_index     (amp_index),
        .amp_value     (amp_value),
        .gate_m00      (gate_m00),
        .gate_m01      (gate_m01),
        .gate_m10      (gate_m10),
        .gate_m11      (gate_m11),
        .cmd           (cmd),
        .stat          (stat),
        .amp_out       (amp_out),
        .z_expectation (z_expectation),
        .status        (status)
    );

    // An out-of-range transaction returns no data
    a_bad_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status) |-> (amp_out == '0 && z_expectation == '0))
        else $error("flagged result carries data");

    // Never take two transactions back to back
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while busy");

    // Read data and expectation never appear together
    a_one_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && z_expectation != '0) |-> (amp_out == '0))
        else $error("both read data and expectation set");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for statevector_gate_engine_top: random and directed
// operations on the amplitude store, checked against an in-bench predictor.
// Depends on sge_pkg and the engine RTL only.
`timescale 1ns / 1ps

module testbench;
    import sge_pkg::*;

    localparam int AMP_DEPTH = 1024;
    localparam int FRAC = 14;
    localparam longint PART_HI = 32767;
    localparam longint PART_LO = -32768;
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 4'd12;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 4'd15;
    localparam logic [31:0] AMP_ONE = 32'h4000_0000;

    typedef struct {
        logic [3:0]  op;
        logic [3:0]  qa;
        logic [3:0]  qb;
        logic [3:0]  qc;
        logic [9:0]  idx;
        logic [31:0] value;
        logic [31:0] m00;
        logic [31:0] m01;
        logic [31:0] m10;
        logic [31:0] m11;
    } op_item_t;

    typedef struct {
        logic [31:0] amp;
        logic [31:0] z;
        logic        status;
    } engine_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [3:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [3:0] operation = '0;
    logic [3:0] qubit_a = '0;
    logic [3:0] qubit_b = '0;
    logic [3:0] qubit_c = '0;
    logic [9:0] amp_index = '0;
    logic [31:0] amp_value = '0;
    logic [31:0] gate_m00 = '0;
    logic [31:0] gate_m01 = '0;
    logic [31:0] gate_m10 = '0;
    logic [31:0] gate_m11 = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [31:0] amp_out;
    logic signed [31:0] z_expectation;
    logic status;

    // Predictor state
    logic [31:0] amp_model [AMP_DEPTH];
    logic [3:0] qubit_count_model = 4'd1;

    op_item_t pending_ops[$];
    engine_result_t expected_results[$];
    op_item_t held_op;
    int accepted_ops = 0;
    int error_count = 0;

    statevector_gate_engine_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .qubit_a(qubit_a), .qubit_b(qubit_b), .qubit_c(qubit_c),
        .amp_index(amp_index), .amp_value(amp_value),
        .gate_m00(gate_m00), .gate_m01(gate_m01), .gate_m10(gate_m10), .gate_m11(gate_m11),
        .out_valid(out_valid), .out_ready(out_ready),
        .amp_out(amp_out), .z_expectation(z_expectation), .status(status)
    );

    always #1 clk = ~clk;

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint re_part(logic [31:0] w);
        return longint'($signed(w[31:16]));
    endfunction

    function automatic longint im_part(logic [31:0] w);
        return longint'($signed(w[15:0]));
    endfunction

    function automatic longint clamp_part(longint v);
        if (v > PART_HI) return PART_HI;
        if (v < PART_LO) return PART_LO;
        return v;
    endfunction

    // Round an exact product sum to nearest, ties upward, then saturate
    function automatic longint round_part(longint s);
        return clamp_part((s + (longint'(1) <<< (FRAC - 1))) >>> FRAC);
    endfunction

    function automatic logic [31:0] join_parts(longint re, longint im);
        return {16'(re), 16'(im)};
    endfunction

    function automatic logic [31:0] mac_pair(logic [31:0] g0, logic [31:0] x0,
                                             logic [31:0] g1, logic [31:0] x1);
        longint sr, si;
        sr = re_part(g0) * re_part(x0) - im_part(g0) * im_part(x0)
           + re_part(g1) * re_part(x1) - im_part(g1) * im_part(x1);
        si = re_part(g0) * im_part(x0) + im_part(g0) * re_part(x0)
           + re_part(g1) * im_part(x1) + im_part(g1) * re_part(x1);
        return join_parts(round_part(sr), round_part(si));
    endfunction

    function automatic int active_qubits(logic [3:0] c);
        if (c == 0) return 1;
        if (c > 10) return 10;
        return c;
    endfunction

    function automatic void swap_entries(int i, int j);
        logic [31:0] t;
        t = amp_model[i];
        amp_model[i] = amp_model[j];
        amp_model[j] = t;
    endfunction

    // Apply one operation to the predicted store and form its result
    function automatic engine_result_t apply_operation(op_item_t it);
        engine_result_t r;
        int cnt, n, ma, mb, mc, slot;
        logic bad;
        logic [31:0] a0, a1;
        longint acc, mag;
        cnt = active_qubits(qubit_count_model);
        n = 1 << cnt;
        r = '{amp: '0, z: '0, status: 1'b0};
        bad = 1'b0;
        case (it.op)
            OP_GATE1Q, OP_EXPZ: bad = it.qa >= cnt;
            OP_CNOT, OP_CZ, OP_SWAP, OP_CY, OP_CPHASE: bad = it.qa >= cnt || it.qb >= cnt;
            OP_TOFFOLI, OP_CSWAP: bad = it.qa >= cnt || it.qb >= cnt || it.qc >= cnt;
            default: bad = 1'b0;
        endcase
        ma = bad ? 0 : 1 << it.qa;
        mb = bad ? 0 : 1 << it.qb;
        mc = bad ? 0 : 1 << it.qc;
        slot = int'(it.idx) & (n - 1);
        if (bad) begin
            r.status = 1'b1;
            return r;
        end
        case (it.op)
            OP_WRITE: amp_model[slot] = it.value;
            OP_READ: r.amp = amp_model[slot];
            OP_BASIS:
            begin
                foreach (amp_model[i]) amp_model[i] = '0;
                amp_model[slot] = AMP_ONE;
            end
            OP_GATE1Q:
                for (int i = 0; i < n; i++)
                    if ((i & ma) == 0) begin
                        a0 = amp_model[i];
                        a1 = amp_model[i | ma];
                        amp_model[i] = mac_pair(it.m00, a0, it.m01, a1);
                        amp_model[i | ma] = mac_pair(it.m10, a0, it.m11, a1);
                    end
            OP_CNOT:
                for (int i = 0; i < n; i++)
                    if ((i & mb) != 0 && (i & ma) == 0) swap_entries(i, i | ma);
            OP_CZ:
                for (int i = 0; i < n; i++)
                    if ((i & mb) != 0 && (i & ma) != 0)
                        amp_model[i] = join_parts(clamp_part(-re_part(amp_model[i])),
                                                  clamp_part(-im_part(amp_model[i])));
            OP_SWAP:
                for (int i = 0; i < n; i++)
                    if ((i & ma) != 0 && (i & mb) == 0) swap_entries(i, (i & ~ma) | mb);
            OP_TOFFOLI:
                for (int i = 0; i < n; i++)
                    if ((i & mb) != 0 && (i & mc) != 0 && (i & ma) == 0)
                        swap_entries(i, i | ma);
            OP_CY:
                for (int i = 0; i < n; i++)
                    if ((i & mb) != 0 && (i & ma) == 0) begin
                        a0 = amp_model[i];
                        a1 = amp_model[i | ma];
                        amp_model[i] = join_parts(im_part(a1), clamp_part(-re_part(a1)));
                        amp_model[i | ma] = join_parts(clamp_part(-im_part(a0)), re_part(a0));
                    end
            OP_CPHASE:
                for (int i = 0; i < n; i++)
                    if ((i & mb) != 0 && (i & ma) != 0)
                        amp_model[i] = mac_pair(amp_model[i], it.m11, '0, '0);
            OP_CSWAP:
                for (int i = 0; i < n; i++)
                    if ((i & mb) != 0 && (i & ma) != 0 && (i & mc) == 0)
                        swap_entries(i, (i & ~ma) | mc);
            OP_EXPZ:
            begin
                acc = 0;
                for (int i = 0; i < n; i++) begin
                    mag = re_part(amp_model[i]) * re_part(amp_model[i])
                        + im_part(amp_model[i]) * im_part(amp_model[i]);
                    acc += ((i & ma) != 0) ? -mag : mag;
                end
                if (acc > 64'sh7FFF_FFFF) acc = 64'sh7FFF_FFFF;
                if (acc < -64'sh8000_0000) acc = -64'sh8000_0000;
                r.z = 32'(acc);
            end
            default: ;
        endcase
        return r;
    endfunction

    // Random packed amplitude: half the time near the unit range, else any word
    function automatic logic [31:0] rand_word();
        if ($urandom_range(1) == 0) return $urandom;
        return {16'($urandom_range(32768) - 16384), 16'($urandom_range(32768) - 16384)};
    endfunction

    function automatic op_item_t make_op(logic [3:0] op, logic [3:0] qa, logic [3:0] qb,
                                         logic [3:0] qc, logic [9:0] idx);
        op_item_t it;
        it = '{op: op, qa: qa, qb: qb, qc: qc, idx: idx, value: rand_word(),
               m00: rand_word(), m01: rand_word(), m10: rand_word(), m11: rand_word()};
        return it;
    endfunction

    function automatic logic [3:0] rand_qubit(int cnt);
        if ($urandom_range(9) == 0) return 4'($urandom);
        return 4'($urandom_range(cnt - 1));
    endfunction

    function automatic op_item_t rand_op(int cnt);
        int pick;
        logic [3:0] op;
        pick = $urandom_range(99);
        if (pick < 12) op = OP_WRITE;
        else if (pick < 24) op = OP_READ;
        else if (pick < 27) op = OP_BASIS;
        else if (pick < 30) op = 4'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        else op = 4'($urandom_range(OP_EXPZ, OP_GATE1Q));
        return make_op(op, rand_qubit(cnt), rand_qubit(cnt), rand_qubit(cnt), 10'($urandom));
    endfunction

    function automatic int send_idle_pct();
        if (accepted_ops < 195) return 33;
        if (accepted_ops < 390) return 87;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (accepted_ops < 195) return 87;
        if (accepted_ops < 390) return 33;
        return 0;
    endfunction

    // Drive operations from the pending queue and predict each accepted transaction
    always @(posedge clk) begin : drive_ops
        logic next_valid;
        if (rst_n) begin
            next_valid = in_valid;
            if (in_valid && in_ready) begin
                expected_results.push_back(apply_operation(held_op));
                accepted_ops++;
                next_valid = 1'b0;
            end
            if (!next_valid && pending_ops.size() > 0 &&
                $urandom_range(99) >= send_idle_pct()) begin
                held_op = pending_ops.pop_front();
                operation <= held_op.op;
                qubit_a <= held_op.qa;
                qubit_b <= held_op.qb;
                qubit_c <= held_op.qc;
                amp_index <= held_op.idx;
                amp_value <= held_op.value;
                gate_m00 <= held_op.m00;
                gate_m01 <= held_op.m01;
                gate_m10 <= held_op.m10;
                gate_m11 <= held_op.m11;
                next_valid = 1'b1;
            end
            in_valid <= next_valid;
        end
    end

    // Check each result transaction against the oldest expectation
    always @(posedge clk) begin : check_results
        engine_result_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result amp %h z %h status %b",
                             $time, amp_out, z_expectation, status);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (amp_out !== want.amp) begin
                        $display("%0t: amp_out expected %h actual %h", $time, want.amp, amp_out);
                        error_count++;
                    end
                    if (z_expectation !== want.z) begin
                        $display("%0t: z_expectation expected %h actual %h",
                                 $time, want.z, z_expectation);
                        error_count++;
                    end
                    if (status !== want.status) begin
                        $display("%0t: status expected %b actual %b", $time, want.status, status);
                        error_count++;
                    end
                end
            end
            out_ready <= $urandom_range(99) >= recv_idle_pct();
        end
    end

    task automatic drain_all();
        while (pending_ops.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_qubit_count(logic [3:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        qubit_count_model = v;
    endtask

    initial begin : stimulus
        logic [3:0] counts [8];
        int lengths [8];
        counts = '{4'd3, 4'd1, 4'd10, 4'd0, 4'd15, 4'd2, 4'd7, 4'd4};
        lengths = '{60, 90, 20, 60, 14, 120, 90, 80};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < 8; p++) begin
            // hold off the sender until the engine is empty, then reconfigure
            drain_all();
            write_qubit_count(counts[p]);
            if (p == 0) begin
                // basis set first so that every entry is defined
                pending_ops.push_back(make_op(OP_BASIS, 0, 0, 0, 10'd5));
                pending_ops.push_back(make_op(OP_READ, 0, 0, 0, 10'd5));
                pending_ops.push_back(make_op(OP_READ, 0, 0, 0, 10'd1021));
                pending_ops.push_back(make_op(OP_WRITE, 0, 0, 0, 10'd0));
                pending_ops[$].value = 32'h7FFF_7FFF;
                pending_ops.push_back(make_op(OP_WRITE, 0, 0, 0, 10'd1));
                pending_ops[$].value = 32'h8000_8000;
                pending_ops.push_back(make_op(OP_WRITE, 0, 0, 0, 10'd1023));
                pending_ops[$].value = 32'hFFFF_0000;
                pending_ops.push_back(make_op(OP_READ, 0, 0, 0, 10'd1));
                pending_ops.push_back(make_op(OP_EXPZ, 4'd0, 0, 0, 0));
                // negation of the most negative part saturates
                pending_ops.push_back(make_op(OP_CZ, 4'd0, 4'd0, 0, 0));
                pending_ops.push_back(make_op(OP_READ, 0, 0, 0, 10'd1));
                pending_ops.push_back(make_op(OP_GATE1Q, 4'd1, 0, 0, 0));
                pending_ops.push_back(make_op(OP_CNOT, 4'd1, 4'd0, 0, 0));
                pending_ops.push_back(make_op(OP_CNOT, 4'd2, 4'd2, 0, 0));
                pending_ops.push_back(make_op(OP_SWAP, 4'd0, 4'd2, 0, 0));
                pending_ops.push_back(make_op(OP_TOFFOLI, 4'd2, 4'd0, 4'd1, 0));
                pending_ops.push_back(make_op(OP_CY, 4'd1, 4'd0, 0, 0));
                pending_ops.push_back(make_op(OP_CPHASE, 4'd0, 4'd1, 0, 0));
                pending_ops.push_back(make_op(OP_CSWAP, 4'd0, 4'd1, 4'd2, 0));
                pending_ops.push_back(make_op(OP_EXPZ, 4'd2, 0, 0, 0));
                pending_ops.push_back(make_op(OP_SPARE_FIRST, 0, 0, 0, 0));
                pending_ops.push_back(make_op(OP_SPARE_LAST, 4'd15, 4'd15, 4'd15, 10'd1023));
                pending_ops.push_back(make_op(OP_GATE1Q, 4'd3, 0, 0, 0));
                pending_ops.push_back(make_op(OP_TOFFOLI, 4'd0, 4'd1, 4'd15, 0));
                pending_ops.push_back(make_op(OP_READ, 0, 0, 0, 10'd6));
            end
            for (int k = 0; k < lengths[p]; k++)
                pending_ops.push_back(rand_op(active_qubits(counts[p])));
        end
        drain_all();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
